// File: rtl/pllm_pkg.sv
// ----------------------------------------------------------------------------
// pllm_pkg
// shared types and constants of the partition linked list manager
// ----------------------------------------------------------------------------
`default_nettype none
package pllm_pkg;

  localparam int NumPartitions = 256;
  localparam int NumVertices   = 1024;
  localparam int PartW         = 8;
  localparam int VertW         = 10;
  localparam int LinkW         = VertW + 1;

  typedef enum logic [1:0] {
    OP_PREPEND = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_MOVE    = 2'd2,
    OP_READ    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [VertW-1:0] vertex_index;
    logic [PartW-1:0] partition;
    logic [PartW-1:0] src_partition;
  } in_item_t;

  typedef struct packed {
    logic [VertW-1:0] head_vertex;
    logic             head_valid;
    logic             status;
  } out_item_t;

  // link: valid bit on top, vertex below
  typedef struct packed {
    logic             valid;
    logic [VertW-1:0] idx;
  } link_t;

  // one memory write request
  typedef struct packed {
    logic             we;
    logic [VertW-1:0] addr;
    link_t            data;
  } lwr_t;

  typedef struct packed {
    logic             we;
    logic [PartW-1:0] addr;
    link_t            data;
  } hwr_t;

endpackage
`default_nettype wire

// File: rtl/pllm_head_table.sv
// ----------------------------------------------------------------------------
// pllm_head_table
// head entry per partition with per-entry valid flags cleared at reset
// ----------------------------------------------------------------------------
`default_nettype none
module pllm_head_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [pllm_pkg::PartW-1:0] rd_addr,
  output pllm_pkg::link_t                 rd_data,
  input  pllm_pkg::hwr_t                  wr
);
  logic [pllm_pkg::VertW-1:0] mem [pllm_pkg::NumPartitions];
  logic [pllm_pkg::NumPartitions-1:0] vld_r;
  logic [pllm_pkg::VertW-1:0] dat_r;
  logic vq_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data.idx;
    end
    dat_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vq_r  <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.addr] <= wr.data.valid;
      end
      vq_r <= vld_r[rd_addr];
    end
  end

  assign rd_data.valid = vq_r;
  assign rd_data.idx   = vq_r ? dat_r : '0;
endmodule
`default_nettype wire

// File: rtl/pllm_link_ram.sv
// ----------------------------------------------------------------------------
// pllm_link_ram
// link table per vertex, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module pllm_link_ram (
  input  wire logic                       clk,
  input  wire logic [pllm_pkg::VertW-1:0] rd_addr,
  output pllm_pkg::link_t                 rd_data,
  input  pllm_pkg::lwr_t                  wr
);
  pllm_pkg::link_t mem [pllm_pkg::NumVertices];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// File: rtl/partition_linked_list_manager_top.sv
// ----------------------------------------------------------------------------
// partition_linked_list_manager_top
// per-partition doubly linked lists of vertices with head query
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data take one operation per transaction: prepend,
//   remove, move between partitions or read a partition head.
//   out_valid/out_ready/out_data return one result per operation: the head of
//   the addressed partition after the operation and a mismatch status.
//   One operation is in flight at a time. A sequencer walks the head table and
//   the next/prev link memories (one read port each, registered reads): a read
//   takes the head; a prepend links the vertex in front of the target head; a
//   remove reads the vertex links and unlinks it; a move between partitions
//   removes and then prepends, a move within one partition only reads the head,
//   and a head mismatch skips the prepend. The result sits in an output
//   register; the next transaction is taken in the cycle after it is handed over.
//   Reset clears every head entry at once (empty lists); link memories hold
//   no reset value. A stalled receiver holds the result and blocks input.
// ----------------------------------------------------------------------------
`default_nettype none
module partition_linked_list_manager_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  pllm_pkg::in_item_t       in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pllm_pkg::out_item_t      out_data
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD1   = 9'b000000010, // links of v and head of list arrive
    S_UNL   = 9'b000000100, // unlink writes
    S_UNL2  = 9'b000001000,
    S_PRE   = 9'b000010000, // head of target requested
    S_PRE1  = 9'b000100000, // head arrives, write links
    S_PRE2  = 9'b001000000,
    S_HRD   = 9'b010000000, // final head read
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  pllm_pkg::in_item_t itm_r;
  logic status_r, status_nxt;
  pllm_pkg::link_t n_r, p_r, h_r, n_nxt, p_nxt, h_nxt;
  pllm_pkg::out_item_t res_r, res_nxt;

  logic [pllm_pkg::PartW-1:0] h_ra;
  logic [pllm_pkg::VertW-1:0] l_ra;
  pllm_pkg::link_t h_rd, n_rd, p_rd;
  pllm_pkg::hwr_t hw;
  pllm_pkg::lwr_t nw, pw;
  pllm_pkg::link_t vlink;
  logic unl_p;

  pllm_head_table u_head (.clk, .rst_n, .rd_addr(h_ra), .rd_data(h_rd), .wr(hw));
  pllm_link_ram u_next (.clk, .rd_addr(l_ra), .rd_data(n_rd), .wr(nw));
  pllm_link_ram u_prev (.clk, .rd_addr(l_ra), .rd_data(p_rd), .wr(pw));

  assign vlink = '{valid: 1'b1, idx: itm_r.vertex_index};
  // the list being unlinked from
  assign unl_p = (itm_r.opcode == pllm_pkg::OP_MOVE);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = res_r;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    n_nxt = n_r;
    p_nxt = p_r;
    h_nxt = h_r;
    res_nxt = res_r;
    h_ra = unl_p ? itm_r.src_partition : itm_r.partition;
    l_ra = itm_r.vertex_index;
    hw = '0;
    nw = '0;
    pw = '0;
    case (state_r)
      S_IDLE: begin
        h_ra = (in_data.opcode == pllm_pkg::OP_MOVE) ? in_data.src_partition
                                                      : in_data.partition;
        l_ra = in_data.vertex_index;
        if (in_valid) begin
          status_nxt = 1'b0;
          case (in_data.opcode)
            pllm_pkg::OP_PREPEND: state_nxt = S_PRE1;
            pllm_pkg::OP_REMOVE:  state_nxt = S_RD1;
            pllm_pkg::OP_MOVE: begin
              state_nxt = (in_data.partition != in_data.src_partition) ? S_RD1 : S_PRE;
              if (in_data.partition == in_data.src_partition) state_nxt = S_HRD;
            end
            default: state_nxt = S_OUT;
          endcase
          if (in_data.opcode == pllm_pkg::OP_READ) state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        n_nxt = n_rd;
        p_nxt = p_rd;
        h_nxt = h_rd;
        if (itm_r.opcode == pllm_pkg::OP_READ) begin
          res_nxt = '{head_vertex: h_rd.idx, head_valid: h_rd.valid, status: 1'b0};
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_UNL;
        end
      end
      S_UNL: begin
        state_nxt = S_UNL2;
        if (n_r.valid && p_r.valid) begin
          nw = '{we: 1'b1, addr: p_r.idx, data: n_r};
          pw = '{we: 1'b1, addr: n_r.idx, data: p_r};
        end else if (n_r.valid) begin
          if (h_r != vlink) status_nxt = 1'b1;
          else begin
            pw = '{we: 1'b1, addr: n_r.idx, data: '0};
            hw = '{we: 1'b1, addr: h_ra, data: n_r};
          end
        end else if (p_r.valid) begin
          nw = '{we: 1'b1, addr: p_r.idx, data: '0};
        end else begin
          if (h_r != vlink) status_nxt = 1'b1;
          else hw = '{we: 1'b1, addr: h_ra, data: '0};
        end
      end
      S_UNL2: begin
        // writes settle; prepend for a clean move, else report
        h_ra = itm_r.partition;
        state_nxt = (unl_p && !status_r) ? S_PRE : S_HRD;
      end
      S_PRE: begin
        h_ra = itm_r.partition;
        state_nxt = S_PRE1;
      end
      S_PRE1: begin
        h_ra = itm_r.partition;
        pw = '{we: 1'b1, addr: itm_r.vertex_index, data: '0};
        nw = '{we: 1'b1, addr: itm_r.vertex_index, data: h_rd};
        hw = '{we: 1'b1, addr: itm_r.partition, data: vlink};
        state_nxt = S_PRE2;
        h_nxt = h_rd;
      end
      S_PRE2: begin
        h_ra = itm_r.partition;
        if (h_r.valid) pw = '{we: 1'b1, addr: h_r.idx, data: vlink};
        state_nxt = S_HRD;
      end
      S_HRD: begin
        // head of the target list was requested in the state before
        h_ra = itm_r.partition;
        state_nxt = S_OUT;
        res_nxt = '{head_vertex: h_rd.idx, head_valid: h_rd.valid, status: status_r};
      end
      S_OUT: begin
        h_ra = in_data.partition;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) itm_r <= in_data;
    n_r <= n_nxt;
    p_r <= p_nxt;
    h_r <= h_nxt;
    res_r <= res_nxt;
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output both open");
`endif
endmodule
`default_nettype wire
